[rtl/eun_pkg.sv]
// shared constants, types and the per-bit step function of the edge unit normal block
// no dependencies
package eun_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int NORMAL_FRAC_BITS = 14;

   localparam int MAG_W     = COORD_WIDTH + 1;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = SQ_W + 1;
   localparam int ACC_W     = SQ_W + 2 * NORMAL_FRAC_BITS + 5;
   localparam int NORM_W    = NORMAL_FRAC_BITS + 2;
   localparam int QUO_W     = NORMAL_FRAC_BITS + 1;
   localparam int NUM_CELLS = NORMAL_FRAC_BITS + 1;
   localparam int IDX_W     = $clog2(NUM_CELLS);

   typedef struct packed {
      logic signed [ACC_W-1:0] rem;   // 4*mag^2*2^2F - 4*u^2*sum
      logic signed [ACC_W-1:0] lin;   // 2*u*sum
      logic [QUO_W-1:0]        quo;
      logic                    neg;
   } lane_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [SUM_W-1:0] sum;
      lane_type         lx;
      lane_type         ly;
   } cell_data_type;

   // try setting bit k of the quotient, keep it if (2n-1)^2*sum stays within bound
   function automatic lane_type lane_step(lane_type ln, logic [SUM_W-1:0] sum,
                                          logic [IDX_W-1:0] k);
      logic signed [ACC_W-1:0] s_ext;
      logic signed [ACC_W-1:0] rem_n;
      logic signed [ACC_W-1:0] lin_n;
      logic signed [ACC_W-1:0] test;
      lane_type                r;
      s_ext = $signed(ACC_W'(sum));
      rem_n = ln.rem - (ln.lin <<< (k + 2)) - (s_ext <<< (2 * k + 2));
      lin_n = ln.lin + (s_ext <<< (k + 1));
      test  = rem_n + (lin_n <<< 1) - s_ext;
      r = ln;
      if (test >= 0) begin
         r.rem = rem_n;
         r.lin = lin_n;
         r.quo = ln.quo | (QUO_W'(1) << k);
      end
      return r;
   endfunction

endpackage

[rtl/eun_front.sv]
// front end: edge vector, magnitudes, squares and squared length
// depends on eun_pkg
module eun_front import eun_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] x1,
   input  logic signed [COORD_WIDTH-1:0] y1,
   input  logic signed [COORD_WIDTH-1:0] x2,
   input  logic signed [COORD_WIDTH-1:0] y2,
   output cell_data_type                 dout
);

   logic signed [MAG_W-1:0] a_diff, b_diff;
   logic             va_ff, va_in;
   logic [MAG_W-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic             na_ff, na_in, nb_ff, nb_in;
   cell_data_type    out_ff, out_in;
   logic [SQ_W-1:0]  sqa, sqb;

   always_comb begin
      a_diff = MAG_W'(y1) - MAG_W'(y2);
      b_diff = MAG_W'(x2) - MAG_W'(x1);
      va_in  = in_valid;
      na_in  = a_diff[MAG_W-1];
      nb_in  = b_diff[MAG_W-1];
      ma_in  = na_in ? MAG_W'(-a_diff) : MAG_W'(a_diff);
      mb_in  = nb_in ? MAG_W'(-b_diff) : MAG_W'(b_diff);
   end

   always_comb begin
      sqa = SQ_W'(ma_ff) * SQ_W'(ma_ff);
      sqb = SQ_W'(mb_ff) * SQ_W'(mb_ff);
      out_in.valid  = va_ff;
      out_in.degen  = (ma_ff == '0) && (mb_ff == '0);
      out_in.sum    = SUM_W'(sqa) + SUM_W'(sqb);
      out_in.lx.rem = $signed(ACC_W'(sqa)) <<< (2 * NORMAL_FRAC_BITS + 2);
      out_in.lx.lin = '0;
      out_in.lx.quo = '0;
      out_in.lx.neg = na_ff;
      out_in.ly.rem = $signed(ACC_W'(sqb)) <<< (2 * NORMAL_FRAC_BITS + 2);
      out_in.ly.lin = '0;
      out_in.ly.quo = '0;
      out_in.ly.neg = nb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         va_ff        <= va_in;
         out_ff.valid <= out_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ma_ff        <= ma_in;
         mb_ff        <= mb_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         out_ff.degen <= out_in.degen;
         out_ff.sum   <= out_in.sum;
         out_ff.lx    <= out_in.lx;
         out_ff.ly    <= out_in.ly;
      end
   end

   assign dout = out_ff;

endmodule

[rtl/eun_cell.sv]
// one cell of the quotient chain: settles one bit of both components
// depends on eun_pkg
module eun_cell import eun_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic [IDX_W-1:0] bit_idx,
   input  cell_data_type    din,
   output cell_data_type    dout
);

   cell_data_type data_ff, data_in;

   always_comb begin
      data_in    = din;
      data_in.lx = lane_step(din.lx, din.sum, bit_idx);
      data_in.ly = lane_step(din.ly, din.sum, bit_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (adv) begin
         data_ff.valid <= data_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff.degen <= data_in.degen;
         data_ff.sum   <= data_in.sum;
         data_ff.lx    <= data_in.lx;
         data_ff.ly    <= data_in.ly;
      end
   end

   assign dout = data_ff;

endmodule

[rtl/edge_unit_normal_2d.sv]
// pipeline: two front stages, one cell per quotient bit, output register
// throughput: one request per cycle unless a held result stalls it, set by the fully pipelined cell chain
// a stalled result holds the whole pipeline, requests are stalled in that time
// reset (synchronous, active high) clears all valid flags, payload is not reset
// depends on eun_pkg, eun_front, eun_cell
module edge_unit_normal_2d import eun_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [NORM_W-1:0]      rsp_normal_x,
   output logic signed [NORM_W-1:0]      rsp_normal_y,
   output logic                          rsp_degenerate
);

   // whole pipeline moves unless a finished result is held
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // chain links, link 0 from the front end
   cell_data_type link [NUM_CELLS+1];

   eun_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .x1       (req_first_x),
      .y1       (req_first_y),
      .x2       (req_second_x),
      .y2       (req_second_y),
      .dout     (link[0])
   );

   // cell i settles quotient bit NORMAL_FRAC_BITS - i, msb first
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      eun_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .bit_idx (IDX_W'(NORMAL_FRAC_BITS - i)),
         .din     (link[i]),
         .dout    (link[i+1])
      );
   end

   // output register: apply signs, zero out degenerate edges
   logic                     valid_ff, valid_in;
   logic signed [NORM_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic                     dg_ff, dg_in;
   cell_data_type            last;

   always_comb begin
      last     = link[NUM_CELLS];
      valid_in = last.valid;
      dg_in    = last.degen;
      nx_in    = last.lx.neg ? -$signed(NORM_W'(last.lx.quo)) : $signed(NORM_W'(last.lx.quo));
      ny_in    = last.ly.neg ? -$signed(NORM_W'(last.ly.quo)) : $signed(NORM_W'(last.ly.quo));
      if (last.degen) begin
         nx_in = '0;
         ny_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         dg_ff <= dg_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_normal_x   = nx_ff;
   assign rsp_normal_y   = ny_ff;
   assign rsp_degenerate = dg_ff;

`ifndef NO_ASSERTIONS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_normal_x == '0 && rsp_normal_y == '0)
      else $error("degenerate result with nonzero normal");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_normal_x != '0 || rsp_normal_y != '0)
      else $error("proper edge gave zero normal");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= $signed(NORM_W'(1) << NORMAL_FRAC_BITS)
                 && rsp_normal_x >= -$signed(NORM_W'(1) << NORMAL_FRAC_BITS))
      else $error("normal_x out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result held");
`endif

endmodule

[verif/tb_top.sv]
// self-checking testbench for edge_unit_normal_2d: directed edges, then random edges
// under three idling patterns, each result checked against a local unit normal predictor
// depends on eun_pkg and the edge_unit_normal_2d rtl
module tb_top import eun_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // one expected result per request
   typedef struct {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic                     degen;
   } normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_WIDTH-1:0] req_first_x = '0;
   logic signed [COORD_WIDTH-1:0] req_first_y = '0;
   logic signed [COORD_WIDTH-1:0] req_second_x = '0;
   logic signed [COORD_WIDTH-1:0] req_second_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [NORM_W-1:0] rsp_normal_x;
   logic signed [NORM_W-1:0] rsp_normal_y;
   logic rsp_degenerate;

   normal_type pending_normals[$];
   int error_count = 0;
   int send_idle_pct = 0;     // chance of a sender gap before a request
   int recv_stall_pct = 0;    // chance of a receiver stall per cycle
   int idle_cycles = 0;       // cycles with no handshake on either side

   localparam int WATCHDOG_LIMIT = 5000;

   always #5 clock = ~clock;

   edge_unit_normal_2d dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_first_x   (req_first_x),
      .req_first_y   (req_first_y),
      .req_second_x  (req_second_x),
      .req_second_y  (req_second_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_normal_x  (rsp_normal_x),
      .rsp_normal_y  (rsp_normal_y),
      .rsp_degenerate(rsp_degenerate)
   );

   // round(|comp| * 2^F / sqrt(sum)), ties away from zero, sign of comp reapplied:
   // the largest n in 0..2^F with (2n-1)^2 * sum <= 4 * comp^2 * 2^2F
   function automatic logic signed [NORM_W-1:0] unit_component(
         logic signed [COORD_WIDTH:0] comp, logic [63:0] sum);
      logic [127:0] mag;
      logic [127:0] bound;
      logic [127:0] odd;
      logic [127:0] lhs;
      longint lo;
      longint hi;
      longint mid;
      mag   = comp < 0 ? 128'(-comp) : 128'(comp);
      bound = (mag * mag) << (2 * NORMAL_FRAC_BITS + 2);
      lo    = 0;
      hi    = longint'(1) << NORMAL_FRAC_BITS;
      while (lo < hi) begin
         mid = (lo + hi + 1) >>> 1;
         odd = 128'(2 * mid - 1);
         lhs = odd * odd * 128'(sum);
         if (lhs <= bound) lo = mid;
         else hi = mid - 1;
      end
      return comp < 0 ? NORM_W'(-lo) : NORM_W'(lo);
   endfunction

   function automatic normal_type edge_normal(logic signed [COORD_WIDTH-1:0] x1,
         logic signed [COORD_WIDTH-1:0] y1, logic signed [COORD_WIDTH-1:0] x2,
         logic signed [COORD_WIDTH-1:0] y2);
      logic signed [COORD_WIDTH:0] a;
      logic signed [COORD_WIDTH:0] b;
      logic [63:0] sum;
      normal_type r;
      // normal direction is (y1 - y2, x2 - x1)
      a = (COORD_WIDTH+1)'(y1) - (COORD_WIDTH+1)'(y2);
      b = (COORD_WIDTH+1)'(x2) - (COORD_WIDTH+1)'(x1);
      // coincident end points: zero vector, flagged
      if (a == 0 && b == 0) begin
         r.nx = '0;
         r.ny = '0;
         r.degen = 1'b1;
         return r;
      end
      sum = 64'(longint'(a) * longint'(a)) + 64'(longint'(b) * longint'(b));
      r.nx = unit_component(a, sum);
      r.ny = unit_component(b, sum);
      r.degen = 1'b0;
      return r;
   endfunction

   // drive one request on the falling edge and hold it until it is taken
   task automatic send_edge(logic signed [COORD_WIDTH-1:0] x1,
         logic signed [COORD_WIDTH-1:0] y1, logic signed [COORD_WIDTH-1:0] x2,
         logic signed [COORD_WIDTH-1:0] y2);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_first_x = x1;
      req_first_y = y1;
      req_second_x = x2;
      req_second_y = y2;
      req_valid = 1'b1;
      pending_normals.push_back(edge_normal(x1, y1, x2, y2));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_quiet();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // hold off until every result has come back
   task automatic wait_drained();
      send_quiet();
      while (pending_normals.size() != 0) @(negedge clock);
   endtask

   // receiver stall pattern, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            $display("%0t: unexpected result nx=%0d ny=%0d degen=%0b", $time,
                     rsp_normal_x, rsp_normal_y, rsp_degenerate);
            error_count++;
         end else begin
            want = pending_normals.pop_front();
            if (rsp_normal_x !== want.nx) begin
               $display("%0t: normal_x expected %0d actual %0d", $time, want.nx,
                        rsp_normal_x);
               error_count++;
            end
            if (rsp_normal_y !== want.ny) begin
               $display("%0t: normal_y expected %0d actual %0d", $time, want.ny,
                        rsp_normal_y);
               error_count++;
            end
            if (rsp_degenerate !== want.degen) begin
               $display("%0t: degenerate expected %0b actual %0b", $time, want.degen,
                        rsp_degenerate);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // extremes, axes, diagonals, coincident points and an edge of exact integer length
   task automatic test_directed();
      send_edge(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_edge(16'sh7fff, -16'sd1, 16'sh7fff, -16'sd1);
      send_edge(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
      send_edge(-16'sh8000, 16'sd0, 16'sh7fff, 16'sd0);
      send_edge(16'sh7fff, 16'sd0, -16'sh8000, 16'sd0);
      send_edge(16'sd0, -16'sh8000, 16'sd0, 16'sh7fff);
      send_edge(16'sd0, 16'sh7fff, 16'sd0, -16'sh8000);
      send_edge(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff);
      send_edge(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000);
      send_edge(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000);
      send_edge(16'sd0, 16'sd0, 16'sd1, 16'sd0);
      send_edge(16'sd0, 16'sd0, 16'sd0, 16'sd1);
      send_edge(16'sd0, 16'sd0, 16'sd1, 16'sd1);
      send_edge(16'sd0, 16'sd0, -16'sd1, 16'sd1);
      send_edge(16'sd0, 16'sd0, 16'sd768, 16'sd1024);
      send_edge(16'sd0, 16'sd0, -16'sd1024, -16'sd768);
      send_edge(16'sd5, 16'sd7, 16'sd6, 16'sd7);
      send_edge(16'sd0, 16'sd0, 16'sd1, 16'sh7fff);
      send_edge(-16'sh8000, 16'sd0, 16'sh7fff, 16'sd1);
      send_edge(16'sh1234, -16'sh4321, 16'sh1234, -16'sh4321);
      wait_drained();
   endtask

   // random edges: full range, short edges and some coincident points
   task automatic test_random(int count);
      logic signed [COORD_WIDTH-1:0] x1;
      logic signed [COORD_WIDTH-1:0] y1;
      logic signed [COORD_WIDTH-1:0] dx;
      logic signed [COORD_WIDTH-1:0] dy;
      int kind;
      for (int i = 0; i < count; i++) begin
         x1 = COORD_WIDTH'($urandom);
         y1 = COORD_WIDTH'($urandom);
         kind = $urandom_range(9);
         if (kind < 5) begin
            send_edge(x1, y1, COORD_WIDTH'($urandom), COORD_WIDTH'($urandom));
         end else if (kind < 9) begin
            dx = COORD_WIDTH'($urandom_range(64)) - 16'sd32;
            dy = COORD_WIDTH'($urandom_range(64)) - 16'sd32;
            send_edge(x1, y1, x1 + dx, y1 + dy);
         end else begin
            send_edge(x1, y1, x1, y1);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 15;
      recv_stall_pct = 71;
      test_directed();
      test_random(460);
      wait_drained();

      send_idle_pct = 71;
      recv_stall_pct = 15;
      test_random(460);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random(460);

      wait_drained();
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
